@@ sv/kpc_pkg.sv @@
// kpc_pkg: shared constants and types for the keyed position cache
// no dependencies
`default_nettype none
package kpc_pkg;
  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int POS_BITS     = 32;
  localparam int USE_BITS     = 16;
  localparam int CNT_BITS     = 32;
  localparam int CFG_BITS     = 7;

  localparam logic [USE_BITS-1:0] USE_LIMIT = 16'd10000;
  localparam logic [USE_BITS-1:0] USE_MAX   = 16'hFFFF;
  localparam logic [CFG_BITS-1:0] CAP_RESET = 7'd64;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

  typedef struct packed {
    logic load;
    logic shift;
    logic bump;
    logic cmp;
  } cell_ctrl_t;
endpackage
`default_nettype wire

@@ sv/keyed_position_cache.sv @@
// keyed_position_cache: top level, control and a row of kpc_cell entries
// uses kpc_pkg and kpc_cell
// a store result is registered from the execute step, a lookup result from the resolve step
// a lookup runs the execute (compare) and resolve steps, a store only execute; busy covers both
// the hit and victim search runs over the registered match and low-use bits of all live cells
// sync reset empties the table, clears counters, sets capacity to 64; no stall on results
`default_nettype none
module keyed_position_cache import kpc_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_command,
  input  wire [KEY_BITS-1:0]   in_file_key,
  input  wire [KEY_BITS-1:0]   in_label_key,
  input  wire [POS_BITS-1:0]   in_position,
  input  wire                  cfg_we,
  input  wire [CFG_BITS-1:0]   cfg_wdata,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [POS_BITS-1:0]  out_found_position,
  output logic                 out_evicted,
  output logic [CNT_BITS-1:0]  out_hit_total,
  output logic [CNT_BITS-1:0]  out_miss_total
);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > CFG_BITS) ? LW : CFG_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_BITS-1:0] cap_r;
  logic [LW-1:0]       live_r, live_nxt;
  logic [IW-1:0]       victim_r, victim_nxt;
  logic [CNT_BITS-1:0] hits_r, hits_nxt, misses_r, misses_nxt;
  logic                cmd_r;
  logic [KEY_BITS-1:0] kf_r, kl_r;
  logic [POS_BITS-1:0] pos_r;

  logic                ov_nxt, oh_nxt, oe_nxt;
  logic [POS_BITS-1:0] of_nxt;

  cell_ctrl_t          ctrl [DEPTH];
  logic [KEY_BITS-1:0] c_file  [DEPTH+1];
  logic [KEY_BITS-1:0] c_label [DEPTH+1];
  logic [POS_BITS-1:0] c_pos   [DEPTH+1];
  logic [USE_BITS-1:0] c_uses  [DEPTH+1];
  logic [DEPTH-1:0]    c_match, c_low, valid;

  assign c_file[DEPTH]  = '0;
  assign c_label[DEPTH] = '0;
  assign c_pos[DEPTH]   = '0;
  assign c_uses[DEPTH]  = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    kpc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk(clk), .ctrl(ctrl[g]), .key_file(kf_r), .key_label(kl_r), .new_pos(pos_r),
      .nb_file(c_file[g+1]), .nb_label(c_label[g+1]), .nb_pos(c_pos[g+1]),
      .nb_uses(c_uses[g+1]), .file_o(c_file[g]), .label_o(c_label[g]),
      .pos_o(c_pos[g]), .uses_o(c_uses[g]), .match_o(c_match[g]), .low_o(c_low[g])
    );
    assign valid[g] = LW'(g) < live_r;
  end

  // effective capacity and eviction decision
  logic [CW-1:0] cap_eff;
  logic          evict;
  logic [IW-1:0] vslot;
  logic [LW-1:0] wr_idx;
  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_r == '0) cap_eff = CW'(1);
    if (cap_eff > CW'(DEPTH)) cap_eff = CW'(DEPTH);
    evict  = (live_r != '0) && (CW'(live_r) >= cap_eff);
    vslot  = (LW'(victim_r) >= live_r) ? '0 : victim_r;
    wr_idx = evict ? live_r - 1'b1 : live_r;
  end

  // oldest match and victim search
  logic          found;
  logic [IW-1:0] first, vic;
  always_comb begin
    found = 1'b0;
    first = '0;
    vic   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && valid[i]) begin
        if (c_match[i]) begin
          found = 1'b1;
          first = IW'(i);
        end else if (c_low[i]) begin
          vic = IW'(i);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load  = (state_r == S_EXEC) && (cmd_r == CMD_STORE) &&
                      (LW'(i) == wr_idx) && (wr_idx < LW'(DEPTH));
      ctrl[i].shift = (state_r == S_EXEC) && (cmd_r == CMD_STORE) && evict &&
                      (IW'(i) >= vslot) && (LW'(i) + 1'b1 < live_r);
      ctrl[i].bump  = (state_r == S_RES) && found && (IW'(i) == first);
      ctrl[i].cmp   = (state_r == S_EXEC) && (cmd_r == CMD_LOOKUP);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    live_nxt   = live_r;
    victim_nxt = victim_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    ov_nxt     = 1'b0;
    oh_nxt     = 1'b0;
    oe_nxt     = 1'b0;
    of_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r == CMD_STORE) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          oe_nxt    = evict;
          if (evict) victim_nxt = '0;
          if (wr_idx < LW'(DEPTH)) live_nxt = wr_idx + 1'b1;
          else live_nxt = wr_idx;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        state_nxt  = S_IDLE;
        ov_nxt     = 1'b1;
        oh_nxt     = found;
        of_nxt     = found ? c_pos[first] : '0;
        victim_nxt = vic;
        if (found) hits_nxt = hits_r + 1'b1;
        else misses_nxt = misses_r + 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_r     <= CAP_RESET;
      live_r    <= '0;
      victim_r  <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      victim_r  <= victim_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      out_valid <= ov_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_command;
      kf_r  <= in_file_key;
      kl_r  <= in_label_key;
      pos_r <= in_position;
    end
    out_hit            <= oh_nxt;
    out_evicted        <= oe_nxt;
    out_found_position <= of_nxt;
    out_hit_total      <= hits_nxt;
    out_miss_total     <= misses_nxt;
  end

  assign busy = state_r != S_IDLE;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(DEPTH)) else $error("live count above depth");
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted)) else $error("hit and eviction together");
  a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RES |=> out_valid) else $error("missing lookup result");
  a_evict_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_STORE && evict) |=> victim_r == '0)
    else $error("victim not reset after eviction");
endmodule
`default_nettype wire

@@ sv/kpc_cell.sv @@
// kpc_cell: one cache entry, compares against the broadcast key pair
// and takes its neighbor's entry when the row compacts; uses kpc_pkg
`default_nettype none
module kpc_cell import kpc_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire                  clk,
  input  cell_ctrl_t           ctrl,
  input  wire [KEY_BITS-1:0]   key_file,
  input  wire [KEY_BITS-1:0]   key_label,
  input  wire [POS_BITS-1:0]   new_pos,
  input  wire [KEY_BITS-1:0]   nb_file,
  input  wire [KEY_BITS-1:0]   nb_label,
  input  wire [POS_BITS-1:0]   nb_pos,
  input  wire [USE_BITS-1:0]   nb_uses,
  output logic [KEY_BITS-1:0]  file_o,
  output logic [KEY_BITS-1:0]  label_o,
  output logic [POS_BITS-1:0]  pos_o,
  output logic [USE_BITS-1:0]  uses_o,
  output logic                 match_o,
  output logic                 low_o
);
  logic [KEY_BITS-1:0] file_r, label_r;
  logic [POS_BITS-1:0] pos_r;
  logic [USE_BITS-1:0] uses_r;
  logic                match_r, low_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      file_r  <= key_file;
      label_r <= key_label;
      pos_r   <= new_pos;
      uses_r  <= '0;
    end else if (ctrl.shift) begin
      file_r  <= nb_file;
      label_r <= nb_label;
      pos_r   <= nb_pos;
      uses_r  <= nb_uses;
    end else if (ctrl.bump && uses_r != USE_MAX) begin
      uses_r  <= uses_r + 1'b1;
    end
    if (ctrl.cmp) begin
      match_r <= (file_r == key_file) && (label_r == key_label);
      low_r   <= uses_r < USE_LIMIT;
    end
  end

  assign file_o  = file_r;
  assign label_o = label_r;
  assign pos_o   = pos_r;
  assign uses_o  = uses_r;
  assign match_o = match_r;
  assign low_o   = low_r;
endmodule
`default_nettype wire

@@ dv/tb_keyed_position_cache.sv @@
// tb_keyed_position_cache: self-checking testbench for keyed_position_cache
// drives lookup and store commands, predicts each result and compares field by field
// depends on kpc_pkg and keyed_position_cache
`timescale 1ns / 100ps
module tb_keyed_position_cache;
  import kpc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct {
    logic        hit;
    logic [31:0] found_position;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } cache_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [31:0] in_file_key;
  logic [31:0] in_label_key;
  logic [31:0] in_position;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        out_valid;
  logic        out_hit;
  logic [31:0] out_found_position;
  logic        out_evicted;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;

  keyed_position_cache dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_file_key(in_file_key),
    .in_label_key(in_label_key), .in_position(in_position),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_found_position(out_found_position), .out_evicted(out_evicted),
    .out_hit_total(out_hit_total), .out_miss_total(out_miss_total)
  );

  // predicted cache contents
  logic [31:0] tbl_file [DEPTH];
  logic [31:0] tbl_label [DEPTH];
  logic [31:0] tbl_pos [DEPTH];
  logic [15:0] tbl_uses [DEPTH];
  int unsigned tbl_live;
  int unsigned tbl_victim;
  logic [31:0] tbl_hits;
  logic [31:0] tbl_misses;
  logic [6:0]  tbl_capacity;

  cache_result_t pending_results[$];
  int          error_count;

  // recently stored keys for producing hits
  logic [31:0] recent_file[$];
  logic [31:0] recent_label[$];

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic cache_result_t predict_command(logic cmd, logic [31:0] fk,
                                                    logic [31:0] lk, logic [31:0] pos);
    cache_result_t r;
    int unsigned cap;
    int unsigned v;
    r.hit = 1'b0;
    r.found_position = '0;
    r.evicted = 1'b0;
    if (cmd == CMD_LOOKUP) begin
      tbl_victim = 0;
      for (int i = 0; i < tbl_live; i++) begin
        if (tbl_file[i] == fk && tbl_label[i] == lk) begin
          r.hit = 1'b1;
          r.found_position = tbl_pos[i];
          if (tbl_uses[i] != USE_MAX) tbl_uses[i]++;
          break;
        end
        if (tbl_uses[i] < USE_LIMIT) tbl_victim = i;
      end
      if (r.hit) tbl_hits++;
      else tbl_misses++;
    end else begin
      cap = tbl_capacity;
      if (cap == 0) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      if (tbl_live > 0 && tbl_live >= cap) begin
        v = (tbl_victim >= tbl_live) ? 0 : tbl_victim;
        for (int i = v; i + 1 < tbl_live; i++) begin
          tbl_file[i] = tbl_file[i+1];
          tbl_label[i] = tbl_label[i+1];
          tbl_pos[i] = tbl_pos[i+1];
          tbl_uses[i] = tbl_uses[i+1];
        end
        tbl_live--;
        tbl_victim = 0;
        r.evicted = 1'b1;
      end
      if (tbl_live < DEPTH) begin
        tbl_file[tbl_live] = fk;
        tbl_label[tbl_live] = lk;
        tbl_pos[tbl_live] = pos;
        tbl_uses[tbl_live] = '0;
        tbl_live++;
      end
    end
    r.hit_total = tbl_hits;
    r.miss_total = tbl_misses;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    cache_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_found_position !== e.found_position)
          report_mismatch("found_position", out_found_position, e.found_position);
        if (out_evicted !== e.evicted) report_mismatch("evicted", out_evicted, e.evicted);
        if (out_hit_total !== e.hit_total)
          report_mismatch("hit_total", out_hit_total, e.hit_total);
        if (out_miss_total !== e.miss_total)
          report_mismatch("miss_total", out_miss_total, e.miss_total);
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_command(logic cmd, logic [31:0] fk, logic [31:0] lk, logic [31:0] pos);
    start <= 1'b1;
    in_command <= cmd;
    in_file_key <= fk;
    in_label_key <= lk;
    in_position <= pos;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_command(cmd, fk, lk, pos));
    if (cmd == CMD_STORE) begin
      recent_file.push_back(fk);
      recent_label.push_back(lk);
      if (recent_file.size() > 80) begin
        void'(recent_file.pop_front());
        void'(recent_label.pop_front());
      end
    end
    start <= 1'b0;
    @(posedge clk);
    idle_gap();
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [6:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    tbl_capacity = cap;
    cfg_we <= 1'b0;
  endtask

  task automatic random_command(int key_span);
    int k;
    if ($urandom_range(0, 1) == 0 && recent_file.size() != 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, recent_file.size() - 1);
      send_command(CMD_LOOKUP, recent_file[k], recent_label[k], $urandom());
    end else if ($urandom_range(0, 2) == 0) begin
      send_command(CMD_LOOKUP, $urandom_range(0, key_span), $urandom_range(0, key_span),
                   $urandom());
    end else begin
      send_command(CMD_STORE, $urandom_range(0, key_span), $urandom_range(0, key_span),
                   $urandom());
    end
  endtask

  task automatic test_directed();
    send_command(CMD_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_command(CMD_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_STORE, 32'h0, 32'h0, 32'h0);
    send_command(CMD_STORE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA);
    send_command(CMD_STORE, 32'h1234_5678, 32'h9ABC_DEF0, 32'hAAAA_5555);
    send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_command(CMD_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_command(CMD_LOOKUP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0);
    send_command(CMD_LOOKUP, 32'h1234_5678, 32'h0, 32'h0);
    send_command(CMD_LOOKUP, 32'h0, 32'h9ABC_DEF0, 32'h0);
    // lower capacity under live count
    set_capacity(7'd2);
    send_command(CMD_STORE, 32'h7, 32'h8, 32'h9);
    send_command(CMD_STORE, 32'hA, 32'hB, 32'hC);
    send_command(CMD_LOOKUP, 32'hA, 32'hB, 32'h0);
    set_capacity(7'd0);
    send_command(CMD_STORE, 32'h1, 32'h2, 32'h3);
    send_command(CMD_LOOKUP, 32'h1, 32'h2, 32'h0);
    send_command(CMD_STORE, 32'h4, 32'h5, 32'h6);
    set_capacity(7'd127);
  endtask

  task automatic test_saturation();
    // repeated hits on one entry, then a miss and an evicting store
    set_capacity(7'd3);
    send_command(CMD_STORE, 32'hC0DE, 32'hBEEF, 32'hFEED);
    send_command(CMD_STORE, 32'h11, 32'h22, 32'h33);
    send_command(CMD_STORE, 32'h44, 32'h55, 32'h66);
    for (int i = 0; i < 300; i++) send_command(CMD_LOOKUP, 32'hC0DE, 32'hBEEF, $urandom());
    send_command(CMD_LOOKUP, 32'h99, 32'h99, 32'h0);
    send_command(CMD_STORE, 32'h77, 32'h88, 32'h99);
    send_command(CMD_LOOKUP, 32'hC0DE, 32'hBEEF, 32'h0);
  endtask

  task automatic test_random();
    logic [6:0] caps[6];
    caps = '{7'd1, 7'd64, 7'd4, 7'd100, 7'd16, 7'd0};
    foreach (caps[c]) begin
      set_capacity(caps[c] == 7'd100 ? 7'($urandom_range(65, 127)) : caps[c]);
      for (int i = 0; i < 130; i++) random_command(c == 1 ? 32'hFFFF_FFFF : 15);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_LOOKUP;
    in_file_key = '0;
    in_label_key = '0;
    in_position = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    error_count = 0;
    tbl_live = 0;
    tbl_victim = 0;
    tbl_hits = '0;
    tbl_misses = '0;
    tbl_capacity = CAP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_keyed_position_cache OK");
    end else begin
      $display("tb_keyed_position_cache NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_keyed_position_cache NOT OK");
    $finish;
  end
endmodule
